// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cds_pkg.sv
// Types, constants and the known chunk type table of the chunk directory scanner.
`timescale 1ns / 1ps

package cds_pkg;

  localparam int KNOWN_COUNT = 20;
  localparam int SLOT_W      = 5;

  localparam logic [31:0] MAP_PLAIN   = 32'h0000_000A;
  localparam logic [31:0] MAP_EXT     = 32'h0000_000B;
  localparam logic [31:0] TYPE_LIMIT  = 32'd1000000;
  localparam logic [31:0] HDR_BYTES   = 32'd8;
  localparam logic [31:0] TYPE_END    = 32'd0;

  localparam logic [31:0] KNOWN_TYPES [KNOWN_COUNT] = '{
    32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
    32'h0000_0006, 32'h0000_0007, 32'h0000_0008, 32'h0000_0009,
    32'h0000_000A, 32'h0000_000B, 32'h0000_000C,
    32'h0001_0003, 32'h0002_0003, 32'h0003_0003, 32'h0004_0003,
    32'h0005_0003, 32'h0006_0003, 32'h0007_0003, 32'h0008_0003,
    32'h0009_0003
  };

  typedef enum logic [2:0] {
    KIND_HDR_OK    = 3'd0,
    KIND_HDR_BAD   = 3'd1,
    KIND_RECORDED  = 3'd2,
    KIND_IGNORED   = 3'd3,
    KIND_UNKNOWN   = 3'd4,
    KIND_DUPLICATE = 3'd5,
    KIND_END       = 3'd6
  } cds_kind_t;

  typedef enum logic [3:0] {
    PH_FILE_HDR  = 4'b0001,
    PH_CHUNK_HDR = 4'b0010,
    PH_SKIP      = 4'b0100,
    PH_STOPPED   = 4'b1000
  } cds_phase_t;

  // One classified header, as passed from the parser to the output side.
  typedef struct packed {
    cds_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       offset;
    logic [31:0]       len_field;
    logic [31:0]       word;
    logic              ext;
  } cds_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cds_q_stat_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } cds_match_t;

  function automatic cds_match_t known_lookup(input logic [31:0] chunk_type);
    cds_match_t m;
    m.hit  = 1'b0;
    m.slot = '0;
    for (int i = KNOWN_COUNT - 1; i >= 0; i--) begin
      if (KNOWN_TYPES[i] == chunk_type) begin
        m.hit  = 1'b1;
        m.slot = SLOT_W'(i);
      end
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/cds_in_if.sv
// Byte input channel of the chunk directory scanner.
`timescale 1ns / 1ps

interface cds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// File: hw/rtl/cds_out_if.sv
// Result channel of the chunk directory scanner.
`timescale 1ns / 1ps

interface cds_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [4:0]  slot_index;
  logic [31:0] data_offset;
  logic [31:0] data_length;
  logic [31:0] header_word;
  logic        extended_variant;

  modport source (output valid, output event_kind, output slot_index, output data_offset,
                  output data_length, output header_word, output extended_variant,
                  input ready);
  modport sink   (input valid, input event_kind, input slot_index, input data_offset,
                  input data_length, input header_word, input extended_variant,
                  output ready);
endinterface

// File: hw/rtl/cds_fifo.sv
// Short record queue between the parser and the output stage.
`timescale 1ns / 1ps

module cds_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cds_pkg::cds_rec_t   push_rec,
  input  logic                pop,
  output cds_pkg::cds_rec_t   head_rec,
  output cds_pkg::cds_q_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cds_pkg::cds_rec_t entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_rec   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// File: hw/rtl/cds_front.sv
// Byte parser: gathers headers, tracks position and skips, classifies chunk types.
`timescale 1ns / 1ps

module cds_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_fire,
  input  logic [7:0]        data_byte,
  input  logic              file_start,
  output logic              rec_valid,
  output cds_pkg::cds_rec_t rec
);

  cds_pkg::cds_phase_t phase_r, phase_nxt, phase_eff;
  logic [2:0]  cnt_r, cnt_nxt, cnt_eff;
  logic [63:0] shift_r, shift_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [cds_pkg::KNOWN_COUNT-1:0] seen_r, seen_nxt, seen_eff;
  logic        var_r, var_nxt, var_eff;
  logic [31:0] lo, hi, dlen;
  cds_pkg::cds_match_t match;

  always_comb begin
    // file_start clears the scan state before the byte is used
    phase_eff = file_start ? cds_pkg::PH_FILE_HDR : phase_r;
    cnt_eff   = file_start ? 3'd0 : cnt_r;
    seen_eff  = file_start ? '0 : seen_r;
    var_eff   = file_start ? 1'b0 : var_r;

    shift_nxt = {data_byte, shift_r[63:8]};
    lo        = shift_nxt[31:0];
    hi        = shift_nxt[63:32];
    dlen      = hi - cds_pkg::HDR_BYTES;
    match     = cds_pkg::known_lookup(lo);

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    var_nxt   = var_r;

    rec_valid     = 1'b0;
    rec           = '0;
    rec.kind      = cds_pkg::KIND_HDR_OK;
    rec.offset    = pos_nxt;
    rec.len_field = hi;
    rec.word      = lo;
    rec.ext       = var_eff;

    if (byte_fire) begin
      phase_nxt  = phase_eff;
      cnt_nxt    = cnt_eff;
      seen_nxt   = seen_eff;
      var_nxt    = var_eff;
      pos_nxt    = (file_start ? 32'd0 : pos_r) + 32'd1;
      rec.offset = pos_nxt;
      unique case (phase_eff) inside
        cds_pkg::PH_FILE_HDR, cds_pkg::PH_CHUNK_HDR: begin
          cnt_nxt = cnt_eff + 3'd1;
          if (cnt_eff == 3'd7) begin
            rec_valid = 1'b1;
            if (phase_eff == cds_pkg::PH_FILE_HDR) begin
              if (hi == cds_pkg::MAP_PLAIN || hi == cds_pkg::MAP_EXT) begin
                var_nxt   = (hi == cds_pkg::MAP_EXT);
                phase_nxt = cds_pkg::PH_CHUNK_HDR;
                rec.kind  = cds_pkg::KIND_HDR_OK;
                rec.ext   = (hi == cds_pkg::MAP_EXT);
              end else begin
                var_nxt   = 1'b0;
                phase_nxt = cds_pkg::PH_STOPPED;
                rec.kind  = cds_pkg::KIND_HDR_BAD;
                rec.ext   = 1'b0;
              end
            end else if (lo == cds_pkg::TYPE_END) begin
              phase_nxt = cds_pkg::PH_STOPPED;
              rec.kind  = cds_pkg::KIND_END;
            end else if (match.hit && lo <= cds_pkg::TYPE_LIMIT && seen_eff[match.slot]) begin
              phase_nxt = cds_pkg::PH_STOPPED;
              rec.kind  = cds_pkg::KIND_DUPLICATE;
              rec.slot  = match.slot;
            end else begin
              if (lo > cds_pkg::TYPE_LIMIT) begin
                rec.kind = cds_pkg::KIND_IGNORED;
              end else if (!match.hit) begin
                rec.kind = cds_pkg::KIND_UNKNOWN;
              end else begin
                rec.kind                = cds_pkg::KIND_RECORDED;
                rec.slot                = match.slot;
                seen_nxt[match.slot]    = 1'b1;
              end
              if (dlen != 32'd0) begin
                skip_nxt  = dlen;
                phase_nxt = cds_pkg::PH_SKIP;
              end
            end
          end
        end
        cds_pkg::PH_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_r == 32'd1) begin
            phase_nxt = cds_pkg::PH_CHUNK_HDR;
          end
        end
        cds_pkg::PH_STOPPED: begin
          phase_nxt = cds_pkg::PH_STOPPED;
        end
        default: begin
          phase_nxt = cds_pkg::PH_FILE_HDR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cds_pkg::PH_FILE_HDR;
      cnt_r   <= 3'd0;
      skip_r  <= 32'd0;
      pos_r   <= 32'd0;
      seen_r  <= '0;
      var_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      var_r   <= var_nxt;
    end
  end

  // header bytes are fully replaced before each use, no reset needed
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      shift_r <= shift_nxt;
    end
  end

endmodule

// File: hw/rtl/cds_back.sv
// Output stage: pops classified records, formats fields, holds them for the sink.
`timescale 1ns / 1ps

module cds_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cds_pkg::cds_rec_t    head_rec,
  input  cds_pkg::cds_q_stat_t q_stat,
  output logic                 pop,
  cds_out_if.source            out_chan
);

  logic        valid_r, valid_nxt;
  logic [2:0]  kind_r;
  logic [4:0]  slot_r;
  logic [31:0] offset_r, length_r, word_r;
  logic        ext_r;
  logic        is_file_hdr;

  assign pop         = !q_stat.empty && (!valid_r || out_chan.ready);
  assign is_file_hdr = (head_rec.kind == cds_pkg::KIND_HDR_OK) ||
                       (head_rec.kind == cds_pkg::KIND_HDR_BAD);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // file header events carry no offset or length
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= head_rec.kind;
      slot_r   <= head_rec.slot;
      offset_r <= is_file_hdr ? 32'd0 : head_rec.offset;
      length_r <= is_file_hdr ? 32'd0 : head_rec.len_field - cds_pkg::HDR_BYTES;
      word_r   <= head_rec.word;
      ext_r    <= head_rec.ext;
    end
  end

  assign out_chan.valid            = valid_r;
  assign out_chan.event_kind       = kind_r;
  assign out_chan.slot_index       = slot_r;
  assign out_chan.data_offset      = offset_r;
  assign out_chan.data_length      = length_r;
  assign out_chan.header_word      = word_r;
  assign out_chan.extended_variant = ext_r;

endmodule

// File: hw/rtl/chunk_directory_scanner.sv
// Top level of the chunk directory scanner: parser, record queue and output stage.
// Usage:
//   in_chan  : one file byte per item (data_byte), file_start high on the first
//              byte of a new file; it clears all scan state before that byte.
//   out_chan : at most one event per byte, on the byte that completes an 8-byte
//              file or chunk header: kind, slot, data offset, data length,
//              header word and variant flag.
// Throughput: one byte per clock while the queue has room. Chunk data bytes are counted down, one per
//   clock, and give no event.
// Path: the edge that accepts the last header byte writes the event into the
//   queue; the output register then loads it from the queue head once it is
//   free or the sink takes its current event, and drives out_chan.valid.
// Stall: events wait in a QUEUE_DEPTH-entry queue plus the output register;
//   in_chan.ready drops only when the queue is full, so bytes keep flowing while
//   the sink is briefly stalled.
// Reset: synchronous, active low rst_n; returns to the file header phase,
//   position zero, all seen bits clear, queue and output empty. No clearing pass.
// After a bad map type, a duplicate known type or an end mark, bytes are still
//   taken but give no events until the next file_start.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chunk_directory_scanner #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic       clk,
  input logic       rst_n,
  cds_in_if.sink    in_chan,
  cds_out_if.source out_chan
);

  logic                 byte_fire;
  logic                 rec_valid;
  cds_pkg::cds_rec_t    rec;
  cds_pkg::cds_rec_t    head_rec;
  cds_pkg::cds_q_stat_t q_stat;
  logic                 pop;

  // Ready is the queue's room alone: the parser never needs more than one slot a byte.
  assign in_chan.ready = !q_stat.full;
  assign byte_fire     = in_chan.valid && in_chan.ready;

  cds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (byte_fire),
    .data_byte  (in_chan.data_byte),
    .file_start (in_chan.file_start),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  cds_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_valid),
    .push_rec (rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  cds_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (head_rec),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // Checks
  `CDS_ASSERT_NOW(a_q_stat_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
  `CDS_ASSERT_NEXT(a_push_reaches_out, rec_valid && q_stat.empty && !out_chan.valid, pop, "event not popped")
  `CDS_ASSERT_NOW(a_slot_only_on_match, out_chan.valid && out_chan.slot_index != 5'd0, out_chan.event_kind == cds_pkg::KIND_RECORDED || out_chan.event_kind == cds_pkg::KIND_DUPLICATE, "slot on non-matching event")
  `CDS_ASSERT_NOW(a_no_push_when_full, rec_valid, !q_stat.full, "push into full queue")

endmodule

// File: tb/sv/chunk_directory_scanner_test.sv
// Self-checking testbench for the chunk directory scanner: random container files in, events checked.
`timescale 1ns / 1ps

module chunk_directory_scanner_test;

  localparam int ITEM_TARGET  = 1800;   // stop generating files past this many bytes
  localparam int MID_PAUSE_AT = 900;    // second full drain point
  localparam int TAIL_ITEMS   = 150;    // last stretch runs with no idling
  localparam int SETTLE_CYCLES = 12;    // margin after the last expected event is in
  localparam int CYCLE_LIMIT  = 300000;

  // One byte waiting to go out on the input channel.
  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       gap_ok;   // sender may idle after this byte
    logic       drain;    // hold this byte until every expected event is in
  } feed_item_t;

  // One event the scanner should emit.
  typedef struct {
    cds_pkg::cds_kind_t kind;
    logic [4:0]  slot;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] word;
    logic        ext;
  } scan_event_t;

  logic clk = 1'b0;
  logic rst_n;

  cds_in_if  in_if();
  cds_out_if out_if();

  chunk_directory_scanner i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #6 clk = ~clk;

  feed_item_t  byte_feed[$];
  scan_event_t expected_events[$];
  feed_item_t  cur_byte;
  scan_event_t got_event;

  int failures    = 0;
  int idle_left   = 0;
  int stall_left  = 0;
  int calm_left   = 0;
  int cycle_count = 0;

  // Generator knobs, read by push_byte.
  logic gen_calm   = 1'b0;
  logic drain_next = 1'b0;

  // ---------------------------------------------------------------------------
  // Scanner shadow state. Mirrors what the block keeps per file.
  // ---------------------------------------------------------------------------
  cds_pkg::cds_phase_t scan_phase;
  logic [2:0]  hdr_count;
  logic [63:0] hdr_shift;
  logic [31:0] skip_left;
  logic [31:0] file_pos;
  logic [cds_pkg::KNOWN_COUNT-1:0] seen_slots;
  logic        ext_flag;

  task automatic scan_reset();
    scan_phase = cds_pkg::PH_FILE_HDR;
    hdr_count  = '0;
    hdr_shift  = '0;
    skip_left  = '0;
    file_pos   = '0;
    seen_slots = '0;
    ext_flag   = 1'b0;
  endtask

  // Advance the shadow state by one accepted byte; queue the event it causes.
  task automatic scan_byte(input logic [7:0] data, input logic start);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] dlen;
    int          hit;
    logic        fire;
    scan_event_t ev;
    if (start) scan_reset();
    file_pos = file_pos + 32'd1;
    fire = 1'b0;
    case (scan_phase)
      cds_pkg::PH_FILE_HDR, cds_pkg::PH_CHUNK_HDR: begin
        // header bytes enter from the top, so after 8 the word is little endian
        hdr_shift = {data, hdr_shift[63:8]};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count == 3'd0) begin
          lo   = hdr_shift[31:0];
          hi   = hdr_shift[63:32];
          fire = 1'b1;
          ev.slot   = '0;
          ev.offset = '0;
          ev.length = '0;
          ev.word   = lo;
          if (scan_phase == cds_pkg::PH_FILE_HDR) begin
            if (hi == cds_pkg::MAP_PLAIN || hi == cds_pkg::MAP_EXT) begin
              ext_flag   = (hi == cds_pkg::MAP_EXT);
              scan_phase = cds_pkg::PH_CHUNK_HDR;
              ev.kind    = cds_pkg::KIND_HDR_OK;
            end else begin
              ext_flag   = 1'b0;
              scan_phase = cds_pkg::PH_STOPPED;
              ev.kind    = cds_pkg::KIND_HDR_BAD;
            end
            ev.ext = ext_flag;
          end else begin
            dlen      = hi - cds_pkg::HDR_BYTES;   // wraps when the length field is below 8
            ev.offset = file_pos;
            ev.length = dlen;
            ev.ext    = ext_flag;
            hit = -1;
            for (int i = 0; i < cds_pkg::KNOWN_COUNT; i++)
              if (hit < 0 && cds_pkg::KNOWN_TYPES[i] == lo) hit = i;
            if (lo == cds_pkg::TYPE_END) begin
              ev.kind    = cds_pkg::KIND_END;
              scan_phase = cds_pkg::PH_STOPPED;
            end else if (lo > cds_pkg::TYPE_LIMIT) begin
              ev.kind = cds_pkg::KIND_IGNORED;
            end else if (hit < 0) begin
              ev.kind = cds_pkg::KIND_UNKNOWN;
            end else if (seen_slots[hit]) begin
              ev.kind    = cds_pkg::KIND_DUPLICATE;
              ev.slot    = 5'(hit);
              scan_phase = cds_pkg::PH_STOPPED;
            end else begin
              seen_slots[hit] = 1'b1;
              ev.kind = cds_pkg::KIND_RECORDED;
              ev.slot = 5'(hit);
            end
            // zero-length data: the next byte already starts the next chunk header
            if (scan_phase != cds_pkg::PH_STOPPED && dlen != 0) begin
              skip_left  = dlen;
              scan_phase = cds_pkg::PH_SKIP;
            end
          end
        end
      end
      cds_pkg::PH_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) scan_phase = cds_pkg::PH_CHUNK_HDR;
      end
      default: ;  // stopped: bytes are swallowed until the next file start
    endcase
    if (fire) expected_events.push_back(ev);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] data, input logic start);
    feed_item_t it;
    it.data   = data;
    it.start  = start;
    it.gap_ok = !gen_calm;
    it.drain  = drain_next;
    drain_next = 1'b0;
    byte_feed.push_back(it);
  endtask

  task automatic push_word(input logic [31:0] w, input logic start);
    push_byte(w[7:0], start);
    push_byte(w[15:8], 1'b0);
    push_byte(w[23:16], 1'b0);
    push_byte(w[31:24], 1'b0);
  endtask

  // One container file. Mostly well formed; some bad map types, truncated
  // headers, huge or wrapped lengths, repeats of known types and end marks.
  task automatic gen_file();
    logic [31:0] map_word;
    logic [31:0] ctype;
    logic [31:0] clen;
    logic [31:0] dlen;
    int          nchunks;
    int          k;
    logic        stopped;
    gen_calm = ($urandom_range(0, 3) == 0);
    k = $urandom_range(0, 19);
    if (k < 9)       map_word = cds_pkg::MAP_PLAIN;
    else if (k < 18) map_word = cds_pkg::MAP_EXT;
    else             map_word = $urandom();
    push_word($urandom(), 1'b1);
    push_word(map_word, 1'b0);
    stopped = !(map_word == cds_pkg::MAP_PLAIN || map_word == cds_pkg::MAP_EXT);
    nchunks = $urandom_range(0, 10);
    for (int c = 0; c < nchunks && !stopped; c++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        ctype = cds_pkg::KNOWN_TYPES[$urandom_range(0, 3)];   // few slots, so repeats happen
      end else if (k < 55) begin
        ctype = cds_pkg::KNOWN_TYPES[$urandom_range(0, cds_pkg::KNOWN_COUNT - 1)];
      end else if (k < 67) begin
        case ($urandom_range(0, 3))
          0:       ctype = 32'd5;
          1:       ctype = 32'h000A_0003;
          2:       ctype = cds_pkg::TYPE_LIMIT;
          default: ctype = $urandom_range(13, 65535);
        endcase
      end else if (k < 80) begin
        case ($urandom_range(0, 2))
          0:       ctype = cds_pkg::TYPE_LIMIT + 32'd1;
          1:       ctype = 32'hFFFF_FFFF;
          default: ctype = $urandom_range(32'd1000001, 32'hFFFF_FFFF);
        endcase
      end else if (k < 85) begin
        ctype = cds_pkg::TYPE_END;
      end else begin
        ctype = cds_pkg::KNOWN_TYPES[$urandom_range(0, cds_pkg::KNOWN_COUNT - 1)];
      end
      k = $urandom_range(0, 99);
      if (k < 75)      clen = cds_pkg::HDR_BYTES + $urandom_range(1, 6);
      else if (k < 88) clen = cds_pkg::HDR_BYTES;
      else if (k < 94) clen = $urandom_range(0, 7);
      else             clen = $urandom() | 32'h0000_0100;
      if ($urandom_range(0, 29) == 0) begin
        // cut off inside a chunk header; the next file start must clear it
        repeat ($urandom_range(1, 7)) push_byte($urandom(), 1'b0);
        stopped = 1'b1;
      end else begin
        push_word(ctype, 1'b0);
        push_word(clen, 1'b0);
        dlen = clen - cds_pkg::HDR_BYTES;
        if (ctype == cds_pkg::TYPE_END) stopped = 1'b1;
        else if (dlen > 32)             stopped = 1'b1;   // stuck skipping until the next file
        else repeat (dlen) push_byte($urandom(), 1'b0);
      end
    end
    if (!stopped && $urandom_range(0, 1) == 0) begin
      push_word(cds_pkg::TYPE_END, 1'b0);
      push_word($urandom(), 1'b0);
    end
    // trailing bytes: either skipped data or swallowed after a stop
    repeat ($urandom_range(0, 4)) push_byte($urandom(), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one byte per handshake, random idle bursts, drain holds.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scan_byte(cur_byte.data, cur_byte.start);
        if (cur_byte.gap_ok && byte_feed.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
          idle_left = $urandom_range(1, 14);
      end
      // the channel is free after this edge unless a byte is still being held
      if (!in_if.valid || in_if.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_if.valid <= 1'b0;
        end else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].drain && expected_events.size() != 0)) begin
          cur_byte = byte_feed.pop_front();
          in_if.valid      <= 1'b1;
          in_if.data_byte  <= cur_byte.data;
          in_if.file_start <= cur_byte.start;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares each event with the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual kind %0d word %0h",
                   $time, out_if.event_kind, out_if.header_word);
          failures++;
        end else begin
          got_event = expected_events.pop_front();
          check_field("event_kind", 32'(got_event.kind), 32'(out_if.event_kind));
          check_field("slot_index", 32'(got_event.slot), 32'(out_if.slot_index));
          check_field("data_offset", got_event.offset, out_if.data_offset);
          check_field("data_length", got_event.length, out_if.data_length);
          check_field("header_word", got_event.word, out_if.header_word);
          check_field("extended_variant", 32'(got_event.ext), 32'(out_if.extended_variant));
        end
      end
      // receiver stalls in bursts, with calm stretches and none near the end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if (byte_feed.size() > TAIL_ITEMS) begin
          case ($urandom_range(0, 49))
            0:          calm_left  = $urandom_range(100, 400);
            1, 2, 3, 4: stall_left = $urandom_range(1, 14);
            default: ;
          endcase
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed bytes, random files, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.file_start = 1'b0;
    out_if.ready     = 1'b0;
    scan_reset();

    // Directed: bad map type straight out of reset (no file start), then a
    // good extended header with an all-ones checksum, then a known chunk with
    // one data byte.
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    push_word(cds_pkg::MAP_EXT, 1'b0);
    push_word(cds_pkg::KNOWN_TYPES[0], 1'b0);
    push_word(cds_pkg::HDR_BYTES + 32'd1, 1'b0);
    push_byte(8'hA5, 1'b0);

    // Random files; the sender stops twice until all events are in.
    drain_next = 1'b1;
    while (byte_feed.size() < MID_PAUSE_AT) gen_file();
    drain_next = 1'b1;
    while (byte_feed.size() < ITEM_TARGET) gen_file();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_feed.size() != 0 || in_if.valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0 && expected_events.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
